// ----- hdl/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and character constants for the format specifier parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Characters the parser reacts to.
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_H     = 8'h68;  // 'h'
  localparam logic [7:0] CHR_L     = 8'h6c;  // 'l'
  localparam logic [7:0] CHR_J     = 8'h6a;  // 'j'
  localparam logic [7:0] CHR_Z     = 8'h7a;  // 'z'
  localparam logic [7:0] CHR_STAR  = 8'h2a;  // '*'
  localparam logic [7:0] CHR_DOT   = 8'h2e;  // '.'
  localparam logic [7:0] CHR_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CHR_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CHR_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CHR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'

  // Bit positions in the flag set.
  localparam int FLAG_MINUS = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_ZERO  = 3;
  localparam int FLAG_HASH  = 4;

  // Length modifier codes.
  localparam logic [2:0] MOD_NONE = 3'd0;
  localparam logic [2:0] MOD_HH   = 3'd1;
  localparam logic [2:0] MOD_LL   = 3'd2;
  localparam logic [2:0] MOD_H    = 3'd3;
  localparam logic [2:0] MOD_L    = 3'd4;
  localparam logic [2:0] MOD_J    = 3'd5;
  localparam logic [2:0] MOD_Z    = 3'd6;

  // Depth of both queues.
  localparam int QUEUE_DEPTH = 2;

  // One character after classification by the front end.
  typedef struct packed {
    logic [7:0] chr;
    logic       start;
    logic       is_nul;
    logic       is_digit;
    logic [3:0] digit_val;
    logic [4:0] flag_bits;
    logic       is_star;
    logic       is_dot;
    logic       is_h;
    logic       is_l;
    logic       is_j;
    logic       is_z;
  } fsp_class_t;

endpackage

// ----- hdl/fsp_queue.sv -----
// ----------------------------------------------------------------------------
// fsp_queue
// Small first-in first-out queue built from registers.
// ----------------------------------------------------------------------------
module fsp_queue #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH     = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] wdata,
  output logic                 full,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] rdata,
  output logic                 empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hdl/fsp_front.sv -----
// ----------------------------------------------------------------------------
// fsp_front
// Input side: accepts characters and classifies them for the parse engine.
// ----------------------------------------------------------------------------
module fsp_front (
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_spec_char,
  input  logic               in_spec_start,
  input  logic               q_full,
  output logic               q_push,
  output fsp_pkg::fsp_class_t cls
);

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full;

  always_comb begin
    cls           = '0;
    cls.chr       = in_spec_char;
    cls.start     = in_spec_start;
    cls.is_nul    = (in_spec_char == fsp_pkg::CHR_NUL);
    cls.is_digit  = in_spec_char inside {[fsp_pkg::CHR_ZERO:fsp_pkg::CHR_NINE]};
    cls.digit_val = in_spec_char[3:0];
    cls.is_star   = (in_spec_char == fsp_pkg::CHR_STAR);
    cls.is_dot    = (in_spec_char == fsp_pkg::CHR_DOT);
    cls.is_h      = (in_spec_char == fsp_pkg::CHR_H);
    cls.is_l      = (in_spec_char == fsp_pkg::CHR_L);
    cls.is_j      = (in_spec_char == fsp_pkg::CHR_J);
    cls.is_z      = (in_spec_char == fsp_pkg::CHR_Z);
    case (in_spec_char)
      fsp_pkg::CHR_MINUS: cls.flag_bits[fsp_pkg::FLAG_MINUS] = 1'b1;
      fsp_pkg::CHR_PLUS:  cls.flag_bits[fsp_pkg::FLAG_PLUS]  = 1'b1;
      fsp_pkg::CHR_SPACE: cls.flag_bits[fsp_pkg::FLAG_SPACE] = 1'b1;
      fsp_pkg::CHR_ZERO:  cls.flag_bits[fsp_pkg::FLAG_ZERO]  = 1'b1;
      fsp_pkg::CHR_HASH:  cls.flag_bits[fsp_pkg::FLAG_HASH]  = 1'b1;
      default:            cls.flag_bits = '0;
    endcase
  end

endmodule

// ----- hdl/fsp_back.sv -----
// ----------------------------------------------------------------------------
// fsp_back
// Parse engine: walks the specifier grammar one classified character per
// cycle unless res_full; emits one packed record when a specifier ends.
// ----------------------------------------------------------------------------
module fsp_back #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16,
  parameter int RES_BITS   = 2 * VALUE_BITS + COUNT_BITS + 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  fsp_pkg::fsp_class_t   q_cls,
  input  logic [VALUE_BITS-1:0] q_arg,
  output logic                  q_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [RES_BITS-1:0]   res_data
);

  typedef enum logic [2:0] {
    PH_FLAGS, PH_WIDTH, PH_STAR, PH_STARDIG, PH_PREC, PH_MOD, PH_MOD2, PH_CONV
  } phase_t;

  localparam int WIDE_BITS = VALUE_BITS + 4;
  localparam logic [WIDE_BITS-1:0] VAL_MAX_W = WIDE_BITS'({(VALUE_BITS - 1){1'b1}});

  phase_t                phase_r, phase_nxt;
  logic [4:0]            flags_r, flags_nxt;
  logic [VALUE_BITS-1:0] width_r, width_nxt;
  logic [VALUE_BITS-1:0] prec_r, prec_nxt;
  logic                  prec_seen_r, prec_seen_nxt;
  logic [2:0]            mod_r, mod_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [1:0]            stars_r, stars_nxt;

  // State after an optional start-of-specifier clear.
  phase_t                b_phase;
  logic [4:0]            b_flags;
  logic [VALUE_BITS-1:0] b_width, b_prec;
  logic                  b_prec_seen;
  logic [2:0]            b_mod;
  logic [COUNT_BITS-1:0] b_count;
  logic [1:0]            b_stars;

  logic [WIDE_BITS-1:0]  w_sum, p_sum, dig_w;
  logic [VALUE_BITS-1:0] width_dig, prec_dig;
  logic                  take, emit, done;
  phase_t                ph;

  assign take  = ~q_empty & ~res_full;
  assign q_pop = take;

  assign b_phase     = q_cls.start ? PH_FLAGS : phase_r;
  assign b_flags     = q_cls.start ? '0 : flags_r;
  assign b_width     = q_cls.start ? '0 : width_r;
  assign b_prec      = q_cls.start ? '0 : prec_r;
  assign b_prec_seen = q_cls.start ? 1'b0 : prec_seen_r;
  assign b_mod       = q_cls.start ? fsp_pkg::MOD_NONE : mod_r;
  assign b_count     = q_cls.start ? '0 : count_r;
  assign b_stars     = q_cls.start ? '0 : stars_r;

  // Decimal accumulate, acc*10 + d, saturating at the largest positive value.
  assign dig_w     = WIDE_BITS'(q_cls.digit_val);
  assign w_sum     = (WIDE_BITS'(b_width) << 3) + (WIDE_BITS'(b_width) << 1) + dig_w;
  assign p_sum     = (WIDE_BITS'(b_prec) << 3) + (WIDE_BITS'(b_prec) << 1) + dig_w;
  assign width_dig = (w_sum > VAL_MAX_W) ? VAL_MAX_W[VALUE_BITS-1:0] : w_sum[VALUE_BITS-1:0];
  assign prec_dig  = (p_sum > VAL_MAX_W) ? VAL_MAX_W[VALUE_BITS-1:0] : p_sum[VALUE_BITS-1:0];

  always_comb begin
    phase_nxt     = b_phase;
    flags_nxt     = b_flags;
    width_nxt     = b_width;
    prec_nxt      = b_prec;
    prec_seen_nxt = b_prec_seen;
    mod_nxt       = b_mod;
    count_nxt     = (b_count == '1) ? b_count : b_count + 1'b1;
    stars_nxt     = b_stars;
    emit          = 1'b0;
    done          = 1'b0;
    ph            = b_phase;
    res_data      = '0;

    if (q_cls.is_nul) begin
      emit     = 1'b1;
      res_data = {5'd0, {VALUE_BITS{1'b0}}, {VALUE_BITS{1'b0}}, 1'b0, 3'd0, 8'd0,
                  {COUNT_BITS{1'b0}}, b_stars, 1'b1};
    end else begin
      // A character that does not fit the current field moves the parse on
      // to the next field, which keeps that field as its phase.
      if (ph == PH_FLAGS) begin
        if (q_cls.flag_bits != '0) begin
          flags_nxt = b_flags | q_cls.flag_bits;
          done      = 1'b1;
        end else begin
          ph        = PH_WIDTH;
          phase_nxt = PH_WIDTH;
        end
      end
      if (!done && ph == PH_WIDTH) begin
        if (q_cls.is_digit) begin
          width_nxt = width_dig;
          done      = 1'b1;
        end else if (q_cls.is_star) begin
          width_nxt = q_arg;
          stars_nxt = b_stars + 1'b1;
          phase_nxt = PH_STAR;
          done      = 1'b1;
        end else begin
          ph        = PH_PREC;
          phase_nxt = PH_PREC;
        end
      end
      if (!done && ph == PH_STAR) begin
        if (q_cls.is_digit) begin
          width_nxt = VALUE_BITS'(q_cls.digit_val);
          phase_nxt = PH_STARDIG;
          done      = 1'b1;
        end else begin
          ph        = PH_PREC;
          phase_nxt = PH_PREC;
        end
      end
      if (!done && ph == PH_STARDIG) begin
        if (q_cls.is_digit) begin
          width_nxt = width_dig;
          done      = 1'b1;
        end else begin
          ph        = PH_PREC;
          phase_nxt = PH_PREC;
        end
      end
      if (!done && ph == PH_PREC) begin
        if (q_cls.is_dot && !b_prec_seen) begin
          prec_seen_nxt = 1'b1;
          prec_nxt      = '0;
          done          = 1'b1;
        end else if (b_prec_seen && q_cls.is_digit) begin
          prec_nxt = prec_dig;
          done     = 1'b1;
        end else if (b_prec_seen && q_cls.is_star) begin
          prec_nxt  = q_arg;
          stars_nxt = b_stars + 1'b1;
          phase_nxt = PH_MOD;
          done      = 1'b1;
        end else begin
          ph        = PH_MOD;
          phase_nxt = PH_MOD;
        end
      end
      if (!done && ph == PH_MOD) begin
        if (q_cls.is_h) begin
          mod_nxt   = fsp_pkg::MOD_H;
          phase_nxt = PH_MOD2;
          done      = 1'b1;
        end else if (q_cls.is_l) begin
          mod_nxt   = fsp_pkg::MOD_L;
          phase_nxt = PH_MOD2;
          done      = 1'b1;
        end else if (q_cls.is_j) begin
          mod_nxt   = fsp_pkg::MOD_J;
          phase_nxt = PH_CONV;
          done      = 1'b1;
        end else if (q_cls.is_z) begin
          mod_nxt   = fsp_pkg::MOD_Z;
          phase_nxt = PH_CONV;
          done      = 1'b1;
        end else begin
          ph        = PH_CONV;
          phase_nxt = PH_CONV;
        end
      end
      if (!done && ph == PH_MOD2) begin
        if (q_cls.is_h && b_mod == fsp_pkg::MOD_H) begin
          mod_nxt   = fsp_pkg::MOD_HH;
          phase_nxt = PH_CONV;
          done      = 1'b1;
        end else if (q_cls.is_l && b_mod == fsp_pkg::MOD_L) begin
          mod_nxt   = fsp_pkg::MOD_LL;
          phase_nxt = PH_CONV;
          done      = 1'b1;
        end else begin
          ph        = PH_CONV;
          phase_nxt = PH_CONV;
        end
      end
      if (!done) begin
        // The conversion character closes the specifier.
        emit     = 1'b1;
        res_data = {b_flags, b_width, (b_prec_seen ? b_prec : {VALUE_BITS{1'b0}}),
                    b_prec_seen, b_mod, q_cls.chr, count_nxt, b_stars, 1'b0};
      end
    end

    if (emit) begin
      phase_nxt     = PH_FLAGS;
      flags_nxt     = '0;
      width_nxt     = '0;
      prec_nxt      = '0;
      prec_seen_nxt = 1'b0;
      mod_nxt       = fsp_pkg::MOD_NONE;
      count_nxt     = '0;
      stars_nxt     = '0;
    end
  end

  assign res_push = take & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAGS;
      flags_r     <= '0;
      width_r     <= '0;
      prec_r      <= '0;
      prec_seen_r <= 1'b0;
      mod_r       <= fsp_pkg::MOD_NONE;
      count_r     <= '0;
      stars_r     <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      width_r     <= width_nxt;
      prec_r      <= prec_nxt;
      prec_seen_r <= prec_seen_nxt;
      mod_r       <= mod_nxt;
      count_r     <= count_nxt;
      stars_r     <= stars_nxt;
    end
  end

endmodule

// ----- hdl/format_spec_parser_core.sv -----
// ----------------------------------------------------------------------------
// format_spec_parser_core
// Printf-style conversion specifier parser, one character per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one character that follows a percent sign,
// a start mark that clears any partial parse, and the next pending integer
// argument, which is taken when the character is a star that reads one. The
// block gathers flags, width, precision and length modifier, and on the
// conversion character pushes one specifier record onto its result queue; a
// NUL character ends the parse with an error record instead. The sustained
// rate is one character per clock cycle while the result queue has room,
// set by the parse engine, which updates its state for each character,
// including a multiply-by-ten accumulate with saturation. Characters pass
// through the item queue to the parse engine, whose records go into the
// result queue. Both sides are two-entry queues, so input keeps flowing
// while results wait to be popped, until the result queue is full.

module format_spec_parser_core #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [7:0]                   in_spec_char,
  input  logic                         in_spec_start,
  input  logic signed [VALUE_BITS-1:0] in_arg_value,
  // Result channel
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [4:0]                   out_flag_set,
  output logic signed [VALUE_BITS-1:0] out_field_width,
  output logic signed [VALUE_BITS-1:0] out_prec_value,
  output logic                         out_prec_given,
  output logic [2:0]                   out_length_mod,
  output logic [7:0]                   out_conversion,
  output logic [COUNT_BITS-1:0]        out_consumed,
  output logic [1:0]                   out_args_used,
  output logic                         out_parse_error
);

  localparam int CLS_BITS = $bits(fsp_pkg::fsp_class_t);
  localparam int ITEM_BITS = CLS_BITS + VALUE_BITS;
  localparam int RES_BITS = 2 * VALUE_BITS + COUNT_BITS + 20;

  fsp_pkg::fsp_class_t    front_cls, back_cls;
  logic                   iq_push, iq_full, iq_pop, iq_empty;
  logic [ITEM_BITS-1:0]   iq_wdata, iq_rdata;
  logic [VALUE_BITS-1:0]  back_arg;
  logic                   rq_push, rq_full;
  logic [RES_BITS-1:0]    rq_wdata, rq_rdata;

  // Front end: accept and classify the character.
  fsp_front u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_spec_char  (in_spec_char),
    .in_spec_start (in_spec_start),
    .q_full        (iq_full),
    .q_push        (iq_push),
    .cls           (front_cls)
  );

  assign iq_wdata = {front_cls, in_arg_value};

  // Queue between the front end and the parse engine.
  fsp_queue #(
    .DATA_BITS (ITEM_BITS),
    .DEPTH     (fsp_pkg::QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (iq_push),
    .wdata (iq_wdata),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty)
  );

  assign back_cls = fsp_pkg::fsp_class_t'(iq_rdata[ITEM_BITS-1:VALUE_BITS]);
  assign back_arg = iq_rdata[VALUE_BITS-1:0];

  // Parse engine.
  fsp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .RES_BITS   (RES_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (iq_empty),
    .q_cls    (back_cls),
    .q_arg    (back_arg),
    .q_pop    (iq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_data (rq_wdata)
  );

  // Result queue; its head drives the result ports.
  fsp_queue #(
    .DATA_BITS (RES_BITS),
    .DEPTH     (fsp_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign {out_flag_set, out_field_width, out_prec_value, out_prec_given, out_length_mod,
          out_conversion, out_consumed, out_args_used, out_parse_error} = rq_rdata;

endmodule

// ----- hdl/fsp_checker.sv -----
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks on the format specifier parser, bound to the top level.
// ----------------------------------------------------------------------------
module fsp_checker #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [4:0]                   out_flag_set,
  input logic signed [VALUE_BITS-1:0] out_field_width,
  input logic signed [VALUE_BITS-1:0] out_prec_value,
  input logic                         out_prec_given,
  input logic [2:0]                   out_length_mod,
  input logic [7:0]                   out_conversion,
  input logic [COUNT_BITS-1:0]        out_consumed,
  input logic [1:0]                   out_args_used,
  input logic                         out_parse_error
);

  // An error record carries nothing but the argument count.
  a_error_record: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_parse_error) |->
      (out_consumed == '0 && out_flag_set == '0 && out_conversion == 8'd0 &&
       out_length_mod == fsp_pkg::MOD_NONE))
    else $error("error record carries nonzero fields");

  // A good record counts at least its conversion character.
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_parse_error) |-> (out_consumed != '0))
    else $error("specifier record with zero consumed count");

  // Without a precision part the precision reads zero.
  a_prec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_prec_given) |-> (out_prec_value == '0))
    else $error("precision value without precision part");

  // At most two stars can read arguments.
  a_args_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_args_used != 2'd3))
    else $error("more than two arguments used");

  // A waiting record holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_conversion) && $stable(out_field_width)))
    else $error("waiting record changed before pop");

endmodule

bind format_spec_parser_core fsp_checker #(
  .VALUE_BITS (VALUE_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_fsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_flag_set    (out_flag_set),
  .out_field_width (out_field_width),
  .out_prec_value  (out_prec_value),
  .out_prec_given  (out_prec_given),
  .out_length_mod  (out_length_mod),
  .out_conversion  (out_conversion),
  .out_consumed    (out_consumed),
  .out_args_used   (out_args_used),
  .out_parse_error (out_parse_error)
);

// ----- bench/tb_format_spec_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_format_spec_parser_core
// Self-checking bench for the printf-style conversion specifier parser.
// ----------------------------------------------------------------------------
// Characters are pushed one per transaction. A scoreboard object replays
// each accepted character through its own parser model and queues the
// specifier record that the character completes, if any. Every popped
// record is compared field by field against the oldest queued one. The
// stimulus is a short directed set, one long specifier that drives the
// width into saturation, and a random mix of well-formed specifiers,
// truncated ones and plain noise. Both sides of the block idle at random,
// except in one steady stretch.
// ----------------------------------------------------------------------------

module tb_format_spec_parser_core;

  localparam int          CLK_HALF      = 5;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          RANDOM_ITEMS  = 1400;
  localparam int          LONG_DIGITS   = 40;
  localparam int          REPORT_LIMIT  = 10;
  localparam logic [31:0] VALUE_MAX     = 32'h7fff_ffff;
  localparam logic [15:0] COUNT_MAX     = 16'hffff;

  // Where the parser stands within one specifier.
  typedef enum logic [2:0] {
    ST_FLAGS,
    ST_WIDTH,
    ST_STAR,
    ST_STAR_DIGITS,
    ST_PREC,
    ST_MOD,
    ST_MOD_PAIR,
    ST_CONV
  } parse_state_t;

  // One specifier record as it appears on the result ports.
  typedef struct packed {
    logic [4:0]  flag_set;
    logic [31:0] field_width;
    logic [31:0] prec_value;
    logic        prec_given;
    logic [2:0]  length_mod;
    logic [7:0]  conversion;
    logic [15:0] consumed;
    logic [1:0]  args_used;
    logic        parse_error;
  } spec_rec_t;

  typedef logic [7:0] char_q_t[$];

  // --------------------------------------------------------------------------
  // Scoreboard: a cycle-free model of the parser plus the queue of records
  // that are still owed by the block.
  // --------------------------------------------------------------------------
  class spec_scoreboard;
    parse_state_t state;
    logic [4:0]   flags_seen;
    logic [31:0]  width_acc;
    logic [31:0]  prec_acc;
    logic         prec_seen;
    logic [2:0]   mod_code;
    logic [15:0]  char_count;
    logic [1:0]   star_count;

    spec_rec_t expected_specs[$];
    int        chars_seen;
    int        records_predicted;
    int        error_records;
    int        records_checked;
    int        mismatches;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      state      = ST_FLAGS;
      flags_seen = '0;
      width_acc  = '0;
      prec_acc   = '0;
      prec_seen  = 1'b0;
      mod_code   = fsp_pkg::MOD_NONE;
      char_count = '0;
      star_count = '0;
    endfunction

    // Decimal accumulate that sticks at the largest positive value.
    function logic [31:0] add_decimal(logic [31:0] acc, logic [31:0] d);
      if (acc > (VALUE_MAX - d) / 10) begin
        return VALUE_MAX;
      end
      return acc * 10 + d;
    endfunction

    function int pending();
      return expected_specs.size();
    endfunction

    // Advance the model by one accepted character; queue the record it ends.
    function void parse_char(logic [7:0] c, logic start, logic [31:0] arg);
      spec_rec_t   rec;
      logic        is_digit;
      logic [31:0] dval;
      bit          done;
      chars_seen++;
      if (start) begin
        reset_state();
      end
      // End of string aborts the parse; only the star count survives.
      if (c == fsp_pkg::CHR_NUL) begin
        rec             = '0;
        rec.args_used   = star_count;
        rec.parse_error = 1'b1;
        expected_specs.push_back(rec);
        records_predicted++;
        error_records++;
        reset_state();
        return;
      end
      if (char_count != COUNT_MAX) begin
        char_count++;
      end
      is_digit = (c >= fsp_pkg::CHR_ZERO) && (c <= fsp_pkg::CHR_NINE);
      dval     = {24'd0, c - fsp_pkg::CHR_ZERO};
      done     = 1'b0;
      // A character that does not fit the current field falls through to
      // the next one in the same step, exactly like the hardware does.
      while (!done) begin
        case (state)
          ST_FLAGS: begin
            case (c)
              fsp_pkg::CHR_MINUS: flags_seen[fsp_pkg::FLAG_MINUS] = 1'b1;
              fsp_pkg::CHR_PLUS:  flags_seen[fsp_pkg::FLAG_PLUS]  = 1'b1;
              fsp_pkg::CHR_SPACE: flags_seen[fsp_pkg::FLAG_SPACE] = 1'b1;
              fsp_pkg::CHR_ZERO:  flags_seen[fsp_pkg::FLAG_ZERO]  = 1'b1;
              fsp_pkg::CHR_HASH:  flags_seen[fsp_pkg::FLAG_HASH]  = 1'b1;
              default:            state = ST_WIDTH;
            endcase
            done = (state == ST_FLAGS);
          end
          ST_WIDTH: begin
            if (is_digit) begin
              width_acc = add_decimal(width_acc, dval);
              done      = 1'b1;
            end else if (c == fsp_pkg::CHR_STAR) begin
              width_acc = arg;
              star_count++;
              state = ST_STAR;
              done  = 1'b1;
            end else begin
              state = ST_PREC;
            end
          end
          ST_STAR: begin
            // Digits right after a star replace the argument.
            if (is_digit) begin
              width_acc = dval;
              state     = ST_STAR_DIGITS;
              done      = 1'b1;
            end else begin
              state = ST_PREC;
            end
          end
          ST_STAR_DIGITS: begin
            if (is_digit) begin
              width_acc = add_decimal(width_acc, dval);
              done      = 1'b1;
            end else begin
              state = ST_PREC;
            end
          end
          ST_PREC: begin
            if (c == fsp_pkg::CHR_DOT && !prec_seen) begin
              prec_seen = 1'b1;
              prec_acc  = '0;
              done      = 1'b1;
            end else if (prec_seen && is_digit) begin
              prec_acc = add_decimal(prec_acc, dval);
              done     = 1'b1;
            end else if (prec_seen && c == fsp_pkg::CHR_STAR) begin
              prec_acc = arg;
              star_count++;
              state = ST_MOD;
              done  = 1'b1;
            end else begin
              state = ST_MOD;
            end
          end
          ST_MOD: begin
            done = 1'b1;
            case (c)
              fsp_pkg::CHR_H: begin
                mod_code = fsp_pkg::MOD_H;
                state    = ST_MOD_PAIR;
              end
              fsp_pkg::CHR_L: begin
                mod_code = fsp_pkg::MOD_L;
                state    = ST_MOD_PAIR;
              end
              fsp_pkg::CHR_J: begin
                mod_code = fsp_pkg::MOD_J;
                state    = ST_CONV;
              end
              fsp_pkg::CHR_Z: begin
                mod_code = fsp_pkg::MOD_Z;
                state    = ST_CONV;
              end
              default: begin
                state = ST_CONV;
                done  = 1'b0;
              end
            endcase
          end
          ST_MOD_PAIR: begin
            if (c == fsp_pkg::CHR_H && mod_code == fsp_pkg::MOD_H) begin
              mod_code = fsp_pkg::MOD_HH;
              state    = ST_CONV;
              done     = 1'b1;
            end else if (c == fsp_pkg::CHR_L && mod_code == fsp_pkg::MOD_L) begin
              mod_code = fsp_pkg::MOD_LL;
              state    = ST_CONV;
              done     = 1'b1;
            end else begin
              state = ST_CONV;
            end
          end
          default: begin
            rec.flag_set    = flags_seen;
            rec.field_width = width_acc;
            rec.prec_value  = prec_seen ? prec_acc : 32'd0;
            rec.prec_given  = prec_seen;
            rec.length_mod  = mod_code;
            rec.conversion  = c;
            rec.consumed    = char_count;
            rec.args_used   = star_count;
            rec.parse_error = 1'b0;
            expected_specs.push_back(rec);
            records_predicted++;
            reset_state();
            done = 1'b1;
          end
        endcase
      end
    endfunction

    function string show(spec_rec_t r);
      return $sformatf({"flags=%02h width=%0d prec=%0d given=%0b mod=%0d conv=%02h ",
                        "consumed=%0d args=%0d err=%0b"},
                       r.flag_set, $signed(r.field_width), $signed(r.prec_value),
                       r.prec_given, r.length_mod, r.conversion, r.consumed,
                       r.args_used, r.parse_error);
    endfunction

    // Compare one popped record against the oldest outstanding prediction.
    function void check_spec(spec_rec_t got);
      spec_rec_t want;
      string     diff;
      if (expected_specs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Record popped with nothing outstanding: %s", show(got));
        end
        return;
      end
      want = expected_specs.pop_front();
      records_checked++;
      diff = "";
      if (got.flag_set    !== want.flag_set)    diff = {diff, " flag_set"};
      if (got.field_width !== want.field_width) diff = {diff, " field_width"};
      if (got.prec_value  !== want.prec_value)  diff = {diff, " prec_value"};
      if (got.prec_given  !== want.prec_given)  diff = {diff, " prec_given"};
      if (got.length_mod  !== want.length_mod)  diff = {diff, " length_mod"};
      if (got.conversion  !== want.conversion)  diff = {diff, " conversion"};
      if (got.consumed    !== want.consumed)    diff = {diff, " consumed"};
      if (got.args_used   !== want.args_used)   diff = {diff, " args_used"};
      if (got.parse_error !== want.parse_error) diff = {diff, " parse_error"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Record %0d differs in%s", records_checked, diff);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and the DUT itself. Every input starts at a known
  // value so nothing floats before reset is released.
  // --------------------------------------------------------------------------
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_push       = 1'b0;
  logic        in_full;
  logic [7:0]  in_spec_char  = '0;
  logic        in_spec_start = 1'b0;
  logic [31:0] in_arg_value  = '0;
  logic        out_empty;
  logic        out_pop       = 1'b0;
  logic [4:0]  out_flag_set;
  logic [31:0] out_field_width;
  logic [31:0] out_prec_value;
  logic        out_prec_given;
  logic [2:0]  out_length_mod;
  logic [7:0]  out_conversion;
  logic [15:0] out_consumed;
  logic [1:0]  out_args_used;
  logic        out_parse_error;

  // While steady is set neither side inserts idle cycles.
  logic        steady        = 1'b0;
  int          cycle_count   = 0;
  int          items_sent    = 0;
  int          random_specs  = 0;
  int          noise_bursts  = 0;

  logic [7:0]  flag_chars [5] = '{fsp_pkg::CHR_MINUS, fsp_pkg::CHR_PLUS,
                                  fsp_pkg::CHR_SPACE, fsp_pkg::CHR_ZERO,
                                  fsp_pkg::CHR_HASH};
  string       conv_chars     = "diouxXcspfeEgGn%";

  spec_scoreboard sb = new();

  always #CLK_HALF clk = ~clk;

  format_spec_parser_core #(
    .VALUE_BITS (32),
    .COUNT_BITS (16)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_spec_char    (in_spec_char),
    .in_spec_start   (in_spec_start),
    .in_arg_value    (in_arg_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_flag_set    (out_flag_set),
    .out_field_width (out_field_width),
    .out_prec_value  (out_prec_value),
    .out_prec_given  (out_prec_given),
    .out_length_mod  (out_length_mod),
    .out_conversion  (out_conversion),
    .out_consumed    (out_consumed),
    .out_args_used   (out_args_used),
    .out_parse_error (out_parse_error)
  );

  // --------------------------------------------------------------------------
  // Monitor. Inputs change only through nonblocking assignments at the
  // edge, so the values read here are the ones the DUT saw at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    spec_rec_t got;
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.parse_char(in_spec_char, in_spec_start, in_arg_value);
      end
      if (out_pop && !out_empty) begin
        got.flag_set    = out_flag_set;
        got.field_width = out_field_width;
        got.prec_value  = out_prec_value;
        got.prec_given  = out_prec_given;
        got.length_mod  = out_length_mod;
        got.conversion  = out_conversion;
        got.consumed    = out_consumed;
        got.args_used   = out_args_used;
        got.parse_error = out_parse_error;
        sb.check_spec(got);
      end
    end
  end

  // The result side raises pop at random, with a chance of 88 in 100. Raising pop
  // while the queue is empty is harmless, so it is not held for a handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(0, 99) >= 12);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d records outstanding.",
               cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Arguments lean toward the extremes of the signed range.
  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Mostly short digit runs; now and then one long enough to overflow.
  function automatic void push_digits(ref char_q_t chars);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
    repeat (n) chars.push_back(fsp_pkg::CHR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // One input transaction. The call starts and ends on a rising edge; push
  // is dropped only during random idle cycles, never within the same step
  // that raises it again.
  task automatic send_char(input logic [7:0] c, input logic start, input logic [31:0] arg);
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_spec_char  <= c;
    in_spec_start <= start;
    in_arg_value  <= arg;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // A directed specifier: the first star takes first_arg, the second takes
  // second_arg, and the first character restarts the parse.
  task automatic send_spec(input string s, input logic [31:0] first_arg,
                           input logic [31:0] second_arg);
    int          stars;
    logic [31:0] arg;
    stars = 0;
    for (int i = 0; i < s.len(); i++) begin
      arg = rand_arg();
      if (s[i] == fsp_pkg::CHR_STAR) begin
        arg = (stars == 0) ? first_arg : second_arg;
        stars++;
      end
      send_char(s[i], i == 0, arg);
    end
  endtask

  // One random specifier. Most are well formed with random content; some
  // are cut short by end of string, restarted midway, or replaced by noise.
  task automatic send_random_spec();
    char_q_t chars;
    int      cut;
    int      restart_at;
    logic    first_start;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, rand_arg());
      end
      noise_bursts++;
      return;
    end
    random_specs++;
    repeat ($urandom_range(0, 3)) chars.push_back(flag_chars[$urandom_range(0, 4)]);
    // Width: none, digits, star, digits then star, star then digits.
    case ($urandom_range(0, 4))
      1: push_digits(chars);
      2: chars.push_back(fsp_pkg::CHR_STAR);
      3: begin
        push_digits(chars);
        chars.push_back(fsp_pkg::CHR_STAR);
      end
      4: begin
        chars.push_back(fsp_pkg::CHR_STAR);
        push_digits(chars);
      end
      default: ;
    endcase
    // Precision: none, bare dot, digits, star, digits then star, star then
    // digits (the first of those digits becomes the conversion).
    case ($urandom_range(0, 5))
      1: chars.push_back(fsp_pkg::CHR_DOT);
      2: begin
        chars.push_back(fsp_pkg::CHR_DOT);
        push_digits(chars);
      end
      3: begin
        chars.push_back(fsp_pkg::CHR_DOT);
        chars.push_back(fsp_pkg::CHR_STAR);
      end
      4: begin
        chars.push_back(fsp_pkg::CHR_DOT);
        push_digits(chars);
        chars.push_back(fsp_pkg::CHR_STAR);
      end
      5: begin
        chars.push_back(fsp_pkg::CHR_DOT);
        chars.push_back(fsp_pkg::CHR_STAR);
        push_digits(chars);
      end
      default: ;
    endcase
    case ($urandom_range(0, 6))
      1: chars.push_back(fsp_pkg::CHR_H);
      2: begin
        chars.push_back(fsp_pkg::CHR_H);
        chars.push_back(fsp_pkg::CHR_H);
      end
      3: chars.push_back(fsp_pkg::CHR_L);
      4: begin
        chars.push_back(fsp_pkg::CHR_L);
        chars.push_back(fsp_pkg::CHR_L);
      end
      5: chars.push_back(fsp_pkg::CHR_J);
      6: chars.push_back(fsp_pkg::CHR_Z);
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) begin
      chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      chars.push_back(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
    end
    // End of string somewhere before the conversion.
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, chars.size() - 1);
      while (chars.size() > cut) void'(chars.pop_back());
      chars.push_back(fsp_pkg::CHR_NUL);
    end
    restart_at = -1;
    if (chars.size() > 1 && $urandom_range(0, 11) == 0) begin
      restart_at = $urandom_range(1, chars.size() - 1);
    end
    first_start = ($urandom_range(0, 7) != 0);
    foreach (chars[i]) begin
      send_char(chars[i], (i == 0) ? first_start : (i == restart_at), rand_arg());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main
    int long_start;
    int long_items;
    int random_start;
    int n_specs;

    // Synchronous reset, held at the start and never repeated.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. All five flags with a star width at the negative limit
    // and a star precision at the positive limit, followed by hh.
    send_spec("-+ #0*.*hhd", 32'h8000_0000, 32'h7fff_ffff);
    // Digits dropped by a star, star argument dropped by the digits after
    // it, precision digits dropped by a star, and the digit after a
    // precision star taken as the conversion.
    send_spec("3*5.9*7", 32'd77, 32'hffff_ffff);
    // A lone l and a lone h, each followed by an unrelated character.
    send_spec("ls", '0, '0);
    send_spec("h%", '0, '0);
    // End of string after a star, and end of string on its own.
    send_spec("*", 32'd12345, '0);
    send_char(fsp_pkg::CHR_NUL, 1'b0, rand_arg());
    send_char(fsp_pkg::CHR_NUL, 1'b1, rand_arg());

    // One specifier with a digit run long enough to saturate the width.
    long_start = items_sent;
    send_char(fsp_pkg::CHR_MINUS, 1'b1, rand_arg());
    repeat (LONG_DIGITS) begin
      send_char(fsp_pkg::CHR_ZERO + 8'($urandom_range(0, 9)), 1'b0, rand_arg());
    end
    send_char(fsp_pkg::CHR_DOT, 1'b0, rand_arg());
    send_char(fsp_pkg::CHR_NINE, 1'b0, rand_arg());
    send_char(fsp_pkg::CHR_J, 1'b0, rand_arg());
    send_char("d", 1'b0, rand_arg());
    long_items = items_sent - long_start;

    // Random part, with a stretch in the middle where nobody idles.
    random_start = items_sent;
    n_specs      = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      steady = (n_specs >= 60 && n_specs < 100);
      send_random_spec();
      n_specs++;
    end
    steady = 1'b0;
    in_push <= 1'b0;

    // Let the result queue drain, then keep clocking so that a stray extra
    // record would still be caught.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters: the directed set, one %0d-character saturating specifier,",
             items_sent, long_items);
    $display("%0d random specifiers and %0d noise bursts; %0d records checked, %0d of them errors.",
             random_specs, noise_bursts, sb.records_checked, sb.error_records);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatching records, %0d still outstanding.", sb.mismatches, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
